FILE: rtl/trm_pkg.sv
// Shared definitions for the register machine execute unit.
// Operation, status and register codes, sizes, and controller/datapath structs.
// No dependencies.
`default_nettype none

package trm_pkg;

  // Memory and stack sizing
  localparam int MEM_WORDS   = 256;
  localparam int ADDR_W      = $clog2(MEM_WORDS);
  localparam int STACK_DEPTH = 50;
  localparam logic [ADDR_W-1:0] SP_TOP = ADDR_W'(MEM_WORDS - 1);

  // Word and divider sizing
  localparam int WORD_W = 32;
  localparam int CNT_W  = $clog2(WORD_W);

  // Operation codes
  localparam logic [3:0] OP_MOVIMM = 4'd0;
  localparam logic [3:0] OP_STORE  = 4'd1;
  localparam logic [3:0] OP_LOAD   = 4'd2;
  localparam logic [3:0] OP_ADD    = 4'd3;
  localparam logic [3:0] OP_SUB    = 4'd4;
  localparam logic [3:0] OP_MUL    = 4'd5;
  localparam logic [3:0] OP_DIV    = 4'd6;
  localparam logic [3:0] OP_PUSH   = 4'd7;
  localparam logic [3:0] OP_POP    = 4'd8;
  localparam logic [3:0] OP_HALT   = 4'd9;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERFLOW  = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW = 3'd2;
  localparam logic [2:0] ST_DIVZERO   = 3'd3;
  localparam logic [2:0] ST_HALTED    = 3'd4;
  localparam logic [2:0] ST_BADREG    = 3'd5;

  // Register indexes
  localparam logic [1:0] REG_AX = 2'd0;
  localparam logic [1:0] REG_BX = 2'd1;
  localparam logic [1:0] REG_CX = 2'd2;
  localparam logic [1:0] REG_DX = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture the incoming instruction, issue memory read
    logic div_start;  // launch the iterative divider
    logic commit;     // write back state and load the output register
  } trm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic needs_div;  // incoming instruction is a divide that will run
    logic div_busy;   // divider still iterating
    logic out_busy;   // output register full and not being taken
  } trm_stat_t;

endpackage

`default_nettype wire

FILE: rtl/trm_div.sv
// Iterative unsigned divider, one quotient bit per cycle.
// Uses trm_pkg for the word width.
`default_nettype none

module trm_div
  import trm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] dividend,
  input  wire logic [WORD_W-1:0] divisor,
  output logic                   busy,
  output logic [WORD_W-1:0]      quotient
);

  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;

  // Trial subtraction of the divisor from the shifted remainder
  assign shifted = {rem, quo[WORD_W-1]};
  assign diff    = shifted - {1'b0, dvs};

  // Control: count down the quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(WORD_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Datapath: restoring division step
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[WORD_W]) begin
        rem <= diff[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], 1'b1};
      end else begin
        rem <= shifted[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

FILE: rtl/trm_ctrl.sv
// Controller state machine of the execute unit.
// Uses trm_pkg for the command and status structs.
`default_nettype none

module trm_ctrl
  import trm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire trm_stat_t stat,
  output trm_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == S_IDLE);

  // Commands for the datapath
  always_comb begin
    cmd.load      = in_ready && in_valid;
    cmd.div_start = cmd.load && stat.needs_div;
    cmd.commit    = (state == S_EXEC) && !stat.out_busy;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.load) begin
          state_next = stat.needs_div ? S_DIV : S_EXEC;
        end
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/trm_dpath.sv
// Datapath: register file, stack pointer, data memory, multiplier, divider
// and output register. Uses trm_pkg and instantiates trm_div.
`default_nettype none

module trm_dpath
  import trm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire trm_cmd_t          cmd,
  output trm_stat_t              stat,
  input  wire logic [3:0]        in_op,
  input  wire logic [1:0]        in_dst,
  input  wire logic [1:0]        in_src,
  input  wire logic [WORD_W-1:0] in_imm,
  input  wire logic [7:0]        in_addr,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [2:0]             out_status,
  output logic [WORD_W-1:0]      out_value,
  output logic [7:0]             out_sp
);

  function automatic logic [WORD_W-1:0] pick(
    input logic [1:0]        idx,
    input logic [WORD_W-1:0] a,
    input logic [WORD_W-1:0] b,
    input logic [WORD_W-1:0] c,
    input logic [WORD_W-1:0] d
  );
    logic [WORD_W-1:0] r;
    case (idx)
      REG_AX:  r = a;
      REG_BX:  r = b;
      REG_CX:  r = c;
      default: r = d;
    endcase
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] mag(input logic [WORD_W-1:0] v);
    return v[WORD_W-1] ? (~v + 1'b1) : v;
  endfunction

  // Architectural state
  logic [WORD_W-1:0] reg_ax, reg_bx, reg_cx, reg_dx;
  logic [ADDR_W-1:0] sp;
  logic [WORD_W-1:0] mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] mem_valid;

  // Captured instruction and first-cycle results
  logic [3:0]        op_q;
  logic [1:0]        dst_q;
  logic [1:0]        src_q;
  logic [WORD_W-1:0] imm_q;
  logic [ADDR_W-1:0] addr_q;
  logic [WORD_W-1:0] rd_data;
  logic              rd_valid;
  logic [WORD_W-1:0] prod;
  logic              neg_q;

  // Incoming-side operand selection
  logic [WORD_W-1:0] in_src_val;
  logic [ADDR_W-1:0] in_addr_w;
  logic [ADDR_W-1:0] raddr;
  logic              in_src_ok;

  // Divider
  logic              div_busy;
  logic [WORD_W-1:0] div_quo;
  logic [WORD_W-1:0] quo_signed;

  // Execute-stage decisions
  logic [WORD_W-1:0] src_val, dst_val, mem_val;
  logic [2:0]        status_c;
  logic [WORD_W-1:0] value_c;
  logic [ADDR_W-1:0] sp_next;
  logic [ADDR_W-1:0] held;
  logic              gpr_we;
  logic [1:0]        gpr_idx;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              src_ok;

  assign in_src_val = pick(in_src, reg_ax, reg_bx, reg_cx, reg_dx);
  assign in_src_ok  = (in_src == REG_BX) || (in_src == REG_CX);
  assign in_addr_w  = ADDR_W'(in_addr);
  assign raddr      = (in_op == OP_POP) ? sp : in_addr_w;

  assign stat.needs_div = (in_op == OP_DIV) && in_src_ok && (in_src_val != '0);
  assign stat.div_busy  = div_busy;
  assign stat.out_busy  = out_valid && !out_ready;

  trm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mag(reg_ax)),
    .divisor  (mag(in_src_val)),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // Capture the instruction, multiply, and note the quotient sign
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= in_op;
      dst_q  <= in_dst;
      src_q  <= in_src;
      imm_q  <= in_imm;
      addr_q <= in_addr_w;
      prod   <= reg_ax * in_src_val;
      neg_q  <= reg_ax[WORD_W-1] ^ in_src_val[WORD_W-1];
    end
  end

  // Registered memory read issued with the transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_data  <= mem[raddr];
      rd_valid <= mem_valid[raddr];
    end
  end

  assign quo_signed = neg_q ? (~div_quo + 1'b1) : div_quo;

  // Execute: work out the result and the state updates
  always_comb begin
    src_val   = pick(src_q, reg_ax, reg_bx, reg_cx, reg_dx);
    dst_val   = pick(dst_q, reg_ax, reg_bx, reg_cx, reg_dx);
    mem_val   = rd_valid ? rd_data : '0;
    src_ok    = (src_q == REG_BX) || (src_q == REG_CX);
    held      = SP_TOP - sp;
    status_c  = ST_OK;
    value_c   = '0;
    sp_next   = sp;
    gpr_we    = 1'b0;
    gpr_idx   = dst_q;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = src_val;
    case (op_q)
      OP_MOVIMM: begin
        gpr_we  = 1'b1;
        value_c = imm_q;
      end
      OP_STORE: begin
        mem_we  = 1'b1;
        value_c = src_val;
      end
      OP_LOAD: begin
        gpr_we  = 1'b1;
        value_c = mem_val;
      end
      OP_ADD: begin
        gpr_we  = 1'b1;
        value_c = dst_val + src_val;
      end
      OP_SUB: begin
        gpr_we  = 1'b1;
        value_c = dst_val - src_val;
      end
      OP_MUL: begin
        if (!src_ok) begin
          status_c = ST_BADREG;
        end else begin
          gpr_we  = 1'b1;
          gpr_idx = REG_AX;
          value_c = prod;
        end
      end
      OP_DIV: begin
        if (!src_ok) begin
          status_c = ST_BADREG;
        end else if (src_val == '0) begin
          status_c = ST_DIVZERO;
        end else begin
          gpr_we  = 1'b1;
          gpr_idx = REG_AX;
          value_c = quo_signed;
        end
      end
      OP_PUSH: begin
        if ((held >= ADDR_W'(STACK_DEPTH)) || (sp == '0)) begin
          status_c = ST_OVERFLOW;
        end else begin
          sp_next   = sp - 1'b1;
          mem_we    = 1'b1;
          mem_waddr = sp - 1'b1;
          mem_wdata = dst_val;
          value_c   = dst_val;
        end
      end
      OP_POP: begin
        if (sp >= SP_TOP) begin
          status_c = ST_UNDERFLOW;
        end else begin
          sp_next = sp + 1'b1;
          gpr_we  = 1'b1;
          value_c = mem_val;
        end
      end
      OP_HALT: status_c = ST_HALTED;
      default: status_c = ST_OK;
    endcase
  end

  // Commit registers, stack pointer, valid bits and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_ax    <= '0;
      reg_bx    <= '0;
      reg_cx    <= '0;
      reg_dx    <= '0;
      sp        <= SP_TOP;
      mem_valid <= '0;
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      if (gpr_we) begin
        case (gpr_idx)
          REG_AX:  reg_ax <= value_c;
          REG_BX:  reg_bx <= value_c;
          REG_CX:  reg_cx <= value_c;
          default: reg_dx <= value_c;
        endcase
      end
      if (mem_we) begin
        mem_valid[mem_waddr] <= 1'b1;
      end
      sp        <= sp_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Memory write port
  always_ff @(posedge clk) begin
    if (cmd.commit && mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status <= status_c;
      out_value  <= value_c;
      out_sp     <= 8'(sp_next);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/toy_register_machine_execute_unit.sv
// Top level of the register machine execute unit.
// Joins trm_ctrl and trm_dpath; uses trm_pkg.
`default_nettype none

// Executes one pre-decoded instruction per input transfer against four
// 32-bit registers, a stack pointer and a 256-word data memory that reads as
// zero after reset, and returns one result per instruction. Instructions are
// taken one at a time. For every instruction the transfer cycle issues the
// memory read and the multiply; the execute state then writes back and loads
// the output register once that register is free. A divide by BX or CX with
// a non-zero divisor first waits for the one-bit-per-cycle divider to run
// its 32 steps. The output register decouples the two sides; a result not
// yet taken delays only the write-back of the following instruction.
module toy_register_machine_execute_unit
  import trm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata: dst_reg[1:0], src_reg[3:2], immediate[35:4], mem_addr[43:36], zero
  input  wire logic [47:0] s_tdata,
  // s_tuser: req_type[3:0]
  input  wire logic [3:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata: result_value[31:0], stack_ptr[39:32]
  output logic [39:0]      m_tdata,
  // m_tuser: status[2:0]
  output logic [2:0]       m_tuser
);

  trm_cmd_t  cmd;
  trm_stat_t stat;

  logic [WORD_W-1:0] value;
  logic [7:0]        sp_out;

  trm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  trm_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (s_tuser),
    .in_dst     (s_tdata[1:0]),
    .in_src     (s_tdata[3:2]),
    .in_imm     (s_tdata[35:4]),
    .in_addr    (s_tdata[43:36]),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_status (m_tuser),
    .out_value  (value),
    .out_sp     (sp_out)
  );

  assign m_tdata = {sp_out, value};

endmodule

`default_nettype wire

FILE: rtl/trm_checker.sv
// Port-level checks for the register machine execute unit, bound to the top.
// Uses trm_pkg for status codes and stack sizing.
`default_nettype none

module trm_checker
  import trm_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [47:0] s_tdata,
  input wire logic [3:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic [2:0]  m_tuser
);

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // No input transfer directly after another
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("instruction accepted while one is in flight");

  // A failed or halting instruction returns a zero value
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_OVERFLOW || m_tuser == ST_UNDERFLOW ||
                 m_tuser == ST_DIVZERO || m_tuser == ST_HALTED ||
                 m_tuser == ST_BADREG) |-> m_tdata[31:0] == '0)
    else $error("non-zero value with failure status");

  // Keep the stack pointer inside the bounded stack area
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[39:32] >= 8'(MEM_WORDS - 1 - STACK_DEPTH)))
    else $error("stack pointer beyond stack depth");

endmodule

bind toy_register_machine_execute_unit trm_checker u_trm_checker (.*);

`default_nettype wire
